// ----- sv/bswc_pkg.sv -----
// Shared types and constants for the bounded spread window counter.
package bswc_pkg;

  localparam int MAX_LEN    = 4096;
  localparam int ADDR_W     = $clog2(MAX_LEN);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SAMPLE_W   = 32;
  localparam int RUN_W      = 23;
  localparam int OUT_DATA_W = ((RUN_W + 7) / 8) * 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register word index taken from paddr[2]
  localparam logic REG_MAX_SPREAD = 1'b0;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    addr_t                      pos;
  } entry_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr;
  } ram_req_t;

endpackage

// ----- sv/bswc_queue_ram.sv -----
// Simple dual-port queue memory with a registered read port.
module bswc_queue_ram
  import bswc_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output entry_t   rdata
);

  entry_t mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- sv/bswc_cfg.sv -----
// APB register block holding the spread limit.
module bswc_cfg
  import bswc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [31:0]           max_spread
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_spread <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MAX_SPREAD: max_spread <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_SPREAD: prdata = max_spread;
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- sv/bounded_spread_window_counter_unit.sv -----
// Counts the contiguous runs of two or more samples whose max minus min stays
// within max_spread, and returns the total on the beat marked tlast. The window
// maximum and minimum live in two monotonic queues held in on-chip memories
// (one read per cycle each). Each sample passes through a pop state, which
// drops entries from the queue tails (both queues drop in parallel), and a check
// state, which advances the window one head entry at a time; every stored entry
// leaves its queue once. A new sample is taken only from the idle state. A tlast
// beat then loads the result register; the result waits if the previous one is
// not yet taken. Samples past 4096 in one sequence are dropped and set too_long,
// which forces run_count to zero. No clearing pass is needed after reset.
module bounded_spread_window_counter_unit
  import bswc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [22:0] run_count, [23] zero
  output logic                  m_tuser,   // [0] too_long
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_POP, ST_CHECK, ST_EMIT} state_t;

  state_t state;
  logic [31:0] max_spread;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic        last_q;
  cnt_t        mx_head, mx_tail, mn_head, mn_tail;
  addr_t       win_start;
  cnt_t        elem_pos;
  logic [RUN_W-1:0] total;
  logic        ovf;
  logic        mx_done, mn_done, mx_pend, mn_pend, mx_fwd, mn_fwd;
  entry_t      mx_hold, mn_hold;
  logic [RUN_W-1:0] run_count_q;
  logic        too_long_q;

  ram_req_t    mx_req, mn_req;
  entry_t      mx_rdata, mn_rdata;
  addr_t       mx_raddr, mn_raddr;
  addr_t       pos;
  entry_t      new_entry, mx_cur, mn_cur;
  logic        mx_pop, mn_pop, both_fin, viol, drop_mx, out_free;
  logic [SAMPLE_W:0] spread_diff;
  addr_t       run_len;

  bswc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_spread (max_spread)
  );

  bswc_queue_ram u_max_ram (.clk(clk), .req(mx_req), .rdata(mx_rdata));
  bswc_queue_ram u_min_ram (.clk(clk), .req(mn_req), .rdata(mn_rdata));

  always_comb begin
    pos       = elem_pos[ADDR_W-1:0];
    new_entry = '{value: sample_q, pos: pos};

    mx_pop = (state == ST_POP) && !mx_done && (mx_tail > mx_head) &&
             (mx_rdata.value <= sample_q);
    mn_pop = (state == ST_POP) && !mn_done && (mn_tail > mn_head) &&
             (mn_rdata.value >= sample_q);
    both_fin = (mx_done || !mx_pop) && (mn_done || !mn_pop);

    // A head read issued on the push edge may hit the slot being written
    mx_cur = mx_pend ? (mx_fwd ? new_entry : mx_rdata) : mx_hold;
    mn_cur = mn_pend ? (mn_fwd ? new_entry : mn_rdata) : mn_hold;

    spread_diff = {mx_cur.value[SAMPLE_W-1], mx_cur.value} -
                  {mn_cur.value[SAMPLE_W-1], mn_cur.value};
    viol    = spread_diff > {1'b0, max_spread};
    drop_mx = mx_cur.pos < mn_cur.pos;
    run_len = pos - win_start;

    unique case (state)
      ST_IDLE: begin
        mx_raddr = addr_t'(mx_tail - cnt_t'(1));
        mn_raddr = addr_t'(mn_tail - cnt_t'(1));
      end
      ST_POP: begin
        mx_raddr = mx_pop ? addr_t'(mx_tail - cnt_t'(2)) : addr_t'(mx_head);
        mn_raddr = mn_pop ? addr_t'(mn_tail - cnt_t'(2)) : addr_t'(mn_head);
      end
      ST_CHECK: begin
        mx_raddr = addr_t'(mx_head + cnt_t'(1));
        mn_raddr = addr_t'(mn_head + cnt_t'(1));
      end
      default: begin
        mx_raddr = addr_t'(mx_head);
        mn_raddr = addr_t'(mn_head);
      end
    endcase

    mx_req = '{we: (state == ST_POP) && both_fin, waddr: addr_t'(mx_tail),
               wdata: new_entry, raddr: mx_raddr};
    mn_req = '{we: (state == ST_POP) && both_fin, waddr: addr_t'(mn_tail),
               wdata: new_entry, raddr: mn_raddr};

    out_free = !m_tvalid || m_tready;
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {{(OUT_DATA_W-RUN_W){1'b0}}, run_count_q};
  assign m_tuser  = too_long_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mx_head    <= '0;
      mx_tail    <= '0;
      mn_head    <= '0;
      mn_tail    <= '0;
      win_start  <= '0;
      elem_pos   <= '0;
      total      <= '0;
      ovf        <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (elem_pos >= cnt_t'(MAX_LEN)) begin
              // drop the sample, flag the sequence
              ovf <= 1'b1;
              if (s_tlast) begin
                state <= ST_EMIT;
              end
            end else begin
              sample_q <= s_tdata;
              last_q   <= s_tlast;
              mx_done  <= 1'b0;
              mn_done  <= 1'b0;
              state    <= ST_POP;
            end
          end
        end
        ST_POP: begin
          if (mx_pop) begin
            mx_tail <= mx_tail - cnt_t'(1);
          end else begin
            mx_done <= 1'b1;
          end
          if (mn_pop) begin
            mn_tail <= mn_tail - cnt_t'(1);
          end else begin
            mn_done <= 1'b1;
          end
          if (both_fin) begin
            // push the sample onto both tails, fetch both heads
            mx_tail <= mx_tail + cnt_t'(1);
            mn_tail <= mn_tail + cnt_t'(1);
            mx_pend <= 1'b1;
            mn_pend <= 1'b1;
            mx_fwd  <= (mx_head == mx_tail);
            mn_fwd  <= (mn_head == mn_tail);
            state   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          mx_hold <= mx_cur;
          mn_hold <= mn_cur;
          mx_fwd  <= 1'b0;
          mn_fwd  <= 1'b0;
          if (viol) begin
            // advance the window past the older of the two heads
            if (drop_mx) begin
              win_start <= mx_cur.pos + addr_t'(1);
              mx_head   <= mx_head + cnt_t'(1);
              mx_pend   <= 1'b1;
              mn_pend   <= 1'b0;
            end else begin
              win_start <= mn_cur.pos + addr_t'(1);
              mn_head   <= mn_head + cnt_t'(1);
              mx_pend   <= 1'b0;
              mn_pend   <= 1'b1;
            end
          end else begin
            total    <= total + RUN_W'(run_len);
            elem_pos <= elem_pos + cnt_t'(1);
            state    <= last_q ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid    <= 1'b1;
            run_count_q <= ovf ? '0 : total;
            too_long_q  <= ovf;
            mx_head     <= '0;
            mx_tail     <= '0;
            mn_head     <= '0;
            mn_tail     <= '0;
            win_start   <= '0;
            elem_pos    <= '0;
            total       <= '0;
            ovf         <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (mx_head <= mx_tail) && (mn_head <= mn_tail))
    else $error("queue head passed its tail");

  a_check_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (mx_tail > mx_head) && (mn_tail > mn_head))
    else $error("window check with an empty queue");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_t'(win_start) <= elem_pos)
    else $error("window start beyond current position");

  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) && m_tuser |-> (m_tdata == '0))
    else $error("overflowed sequence reported a nonzero count");

endmodule

// ----- tb/sv/bounded_spread_window_counter_unit_tb.sv -----
// Testbench for the bounded spread window counter: streams sample sequences and checks totals.
module bounded_spread_window_counter_unit_tb;
  import bswc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] MAX_SPREAD_ADDR = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR      = 3'd4;
  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    logic [RUN_W-1:0] run_count;
    logic             too_long;
  } tally_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;   // [31:0] sample
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [22:0] run_count, [23] zero
  logic                  m_tuser;        // [0] too_long
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bounded_spread_window_counter_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #20_000_000;
    $display("bounded_spread_window_counter_unit_tb NOT OK");
    $finish;
  end

  // Window tracker: own copy of the sequence, spread limit and monotonic position queues
  longint spread_lim = 0;
  longint seq_val [MAX_LEN];
  int     hi_q [$];
  int     lo_q [$];
  int     win_lo = 0;
  int     n_taken = 0;
  longint run_total = 0;
  bit     seq_over = 1'b0;
  tally_t tally_q [$];

  int  fail_count = 0;
  bit  idle_on = 1'b1;
  int  sink_hold = 0;

  function automatic void absorb_sample(logic [31:0] value, bit last);
    longint v;
    tally_t t;
    v = longint'(signed'(value));
    if (n_taken >= MAX_LEN) begin
      seq_over = 1'b1;
    end else begin
      seq_val[n_taken] = v;
      while (hi_q.size() > 0 && seq_val[hi_q[$]] <= v) void'(hi_q.pop_back());
      hi_q.push_back(n_taken);
      while (lo_q.size() > 0 && seq_val[lo_q[$]] >= v) void'(lo_q.pop_back());
      lo_q.push_back(n_taken);
      // advance the window start until the spread fits; the newest sample always stays
      while (seq_val[hi_q[0]] - seq_val[lo_q[0]] > spread_lim) begin
        win_lo++;
        while (hi_q[0] < win_lo) void'(hi_q.pop_front());
        while (lo_q[0] < win_lo) void'(lo_q.pop_front());
      end
      run_total += n_taken - win_lo;
      n_taken++;
    end
    if (last) begin
      t.run_count = seq_over ? '0 : run_total[RUN_W-1:0];
      t.too_long  = seq_over;
      tally_q.push_back(t);
      hi_q.delete();
      lo_q.delete();
      win_lo = 0;
      n_taken = 0;
      run_total = 0;
      seq_over = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : check_result
    tally_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (tally_q.size() == 0) begin
        report_mismatch("unexpected result, run_count", -1, m_tdata[RUN_W-1:0]);
      end else begin
        want = tally_q.pop_front();
        if (m_tdata[RUN_W-1:0] !== want.run_count)
          report_mismatch("run_count", want.run_count, m_tdata[RUN_W-1:0]);
        if (m_tuser !== want.too_long)
          report_mismatch("too_long", want.too_long, m_tuser);
      end
    end
  end

  // Result side: randomly hold m_tready low while idling is on
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      sink_hold <= $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == REG_MAX_SPREAD)
      spread_lim = longint'(data);
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [31:0] value, input bit last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tlast <= last;
    absorb_sample(value, last);
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait until every pending total has come back
  task automatic drain;
    s_tvalid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_sequence(input logic [31:0] vals [$]);
    foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);
  endtask

  function automatic logic [31:0] pick_sample(logic [31:0] base, logic [31:0] reach);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? INT_MAX : INT_MIN;
      default: return base + $urandom_range(0, reach);
    endcase
  endfunction

  task automatic test_directed_cases;
    // reset spread is zero: only runs of equal values count
    send_sequence('{32'd17});
    send_sequence('{INT_MIN, INT_MAX, 32'd0, 32'hffff_ffff, 32'd1, INT_MAX, INT_MAX});
    send_sequence('{32'd5, 32'd5, 32'd5, 32'hffff_fffd});
    drain();
    // full-range difference needs the 33rd bit
    cfg_write(MAX_SPREAD_ADDR, 32'hffff_ffff);
    send_sequence('{INT_MAX, INT_MIN, INT_MAX, INT_MIN});
    drain();
    cfg_write(MAX_SPREAD_ADDR, 32'hffff_fffe);
    cfg_write(SPARE_ADDR, 32'h0000_0000);
    send_sequence('{INT_MAX, INT_MIN, INT_MAX, INT_MIN});
    drain();
  endtask

  task automatic test_length_limit;
    int k;
    cfg_write(MAX_SPREAD_ADDR, 32'hffff_ffff);
    // exactly the built length gives the largest total
    for (k = 0; k < MAX_LEN; k++) send_sample($urandom, k == MAX_LEN - 1);
    // three past the built length sets the overflow flag
    for (k = 0; k < MAX_LEN + 3; k++) send_sample($urandom, k == MAX_LEN + 2);
    send_sequence('{32'd3, 32'd9});
    drain();
  endtask

  task automatic random_phase(input logic [31:0] spread, input int n_items);
    int sent;
    int len;
    int k;
    logic [31:0] base;
    logic [31:0] reach;
    cfg_write(MAX_SPREAD_ADDR, spread);
    if ($urandom_range(0, 1)) cfg_write(SPARE_ADDR, $urandom);
    reach = (spread < 32'h4000_0000) ? spread * 2 + 1 : 32'hffff_ffff;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      base = $urandom;
      for (k = 0; k < len; k++) send_sample(pick_sample(base, reach), k == len - 1);
      sent += len;
    end
    drain();
  endtask

  task automatic test_random_sequences;
    random_phase(32'd0, 100);
    random_phase($urandom_range(1, 16), 100);
    random_phase($urandom_range(17, 100000), 100);
    random_phase($urandom, 100);
    random_phase(32'hffff_ffff, 100);
    random_phase(32'h8000_0000, 100);
    // close the run with both sides streaming freely
    idle_on = 1'b0;
    random_phase($urandom_range(0, 64), 100);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_length_limit();
    test_random_sequences();
    drain();
    if (fail_count == 0)
      $display("bounded_spread_window_counter_unit_tb OK");
    else
      $display("bounded_spread_window_counter_unit_tb NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/bswc_pkg.sv
sv/bswc_queue_ram.sv
sv/bswc_cfg.sv
sv/bounded_spread_window_counter_unit.sv
tb/sv/bounded_spread_window_counter_unit_tb.sv
